// ===== rtl/m3i_pkg.sv =====
package m3i_pkg;

  // Number format of matrix and inverse elements
  localparam int DW = 32;
  localparam int FW = 16;
  localparam int NEL = 9;

  // Exact intermediate widths
  localparam int PROD_W = 2 * DW;            // element x element
  localparam int COF_W = PROD_W + 1;         // signed cofactor
  localparam int CMAG_W = PROD_W;            // cofactor magnitude
  localparam int TERM_W = DW + CMAG_W;       // |m| x |c|
  localparam int DET_W = TERM_W + 2;         // signed sum of three terms
  localparam int DMAG_W = DET_W - 1;         // determinant magnitude
  localparam int REM_W = DMAG_W + 1;         // divider partial remainder
  localparam int QB = 2 * FW;                // quotient bits below the top bit
  localparam int QW = QB + 1;                // quotient register width

  // Pipeline stage map
  localparam int COF_ST = 2;
  localparam int DET_ST = 6;
  localparam int DIV_ST = QB + 2;
  localparam int COF_BASE = 0;
  localparam int DET_BASE = COF_BASE + COF_ST;
  localparam int DIV_BASE = DET_BASE + DET_ST;
  localparam int NST = DIV_BASE + DIV_ST;

  typedef logic signed [DW-1:0] elem_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [COF_W-1:0] cof_t;
  typedef logic [CMAG_W-1:0] cmag_t;
  typedef logic [DMAG_W-1:0] dmag_t;
  typedef logic signed [DET_W-1:0] det_t;
  typedef logic [REM_W-1:0] rem_t;
  typedef logic [3:0] eidx_t;

  // Saturation limits as magnitudes
  localparam logic [DW-1:0] LIM_POS = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] LIM_NEG = {1'b1, {(DW-1){1'b0}}};

  // Cofactor k = m[p]*m[q] - m[r]*m[s], column-major element numbers
  localparam eidx_t COF_IDX [NEL][4] = '{
    '{4'd4, 4'd8, 4'd7, 4'd5},
    '{4'd7, 4'd2, 4'd1, 4'd8},
    '{4'd1, 4'd5, 4'd4, 4'd2},
    '{4'd6, 4'd5, 4'd3, 4'd8},
    '{4'd0, 4'd8, 4'd6, 4'd2},
    '{4'd3, 4'd2, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd6, 4'd4},
    '{4'd6, 4'd1, 4'd0, 4'd7},
    '{4'd0, 4'd4, 4'd3, 4'd1}
  };

endpackage

// ===== rtl/m3i_in_if.sv =====
interface m3i_in_if;
  logic valid;
  logic ready;
  m3i_pkg::elem_t in_m0;
  m3i_pkg::elem_t in_m1;
  m3i_pkg::elem_t in_m2;
  m3i_pkg::elem_t in_m3;
  m3i_pkg::elem_t in_m4;
  m3i_pkg::elem_t in_m5;
  m3i_pkg::elem_t in_m6;
  m3i_pkg::elem_t in_m7;
  m3i_pkg::elem_t in_m8;

  modport source (
    output valid, in_m0, in_m1, in_m2, in_m3, in_m4, in_m5, in_m6, in_m7, in_m8,
    input ready
  );
  modport sink (
    input valid, in_m0, in_m1, in_m2, in_m3, in_m4, in_m5, in_m6, in_m7, in_m8,
    output ready
  );
endinterface

// ===== rtl/m3i_out_if.sv =====
interface m3i_out_if;
  logic valid;
  logic ready;
  m3i_pkg::elem_t inv_m0;
  m3i_pkg::elem_t inv_m1;
  m3i_pkg::elem_t inv_m2;
  m3i_pkg::elem_t inv_m3;
  m3i_pkg::elem_t inv_m4;
  m3i_pkg::elem_t inv_m5;
  m3i_pkg::elem_t inv_m6;
  m3i_pkg::elem_t inv_m7;
  m3i_pkg::elem_t inv_m8;
  logic singular;

  modport source (
    output valid, inv_m0, inv_m1, inv_m2, inv_m3, inv_m4, inv_m5, inv_m6, inv_m7,
    output inv_m8, singular,
    input ready
  );
  modport sink (
    input valid, inv_m0, inv_m1, inv_m2, inv_m3, inv_m4, inv_m5, inv_m6, inv_m7,
    input inv_m8, singular,
    output ready
  );
endinterface

// ===== rtl/m3i_cof.sv =====
module m3i_cof (
  input  logic                             clk,
  input  logic [m3i_pkg::COF_ST-1:0]       en,
  input  m3i_pkg::elem_t                   a,
  input  m3i_pkg::elem_t                   b,
  input  m3i_pkg::elem_t                   c,
  input  m3i_pkg::elem_t                   d,
  output m3i_pkg::cof_t                    cof
);

  m3i_pkg::prod_t p;
  m3i_pkg::prod_t q;

  // Register both products
  always_ff @(posedge clk) begin
    if (en[0]) begin
      p <= a * b;
      q <= c * d;
    end
  end

  // Form the exact difference
  always_ff @(posedge clk) begin
    if (en[1]) begin
      cof <= m3i_pkg::cof_t'(p) - m3i_pkg::cof_t'(q);
    end
  end

endmodule

// ===== rtl/m3i_det.sv =====
module m3i_det (
  input  logic                        clk,
  input  logic [m3i_pkg::DET_ST-1:0]  en,
  input  m3i_pkg::elem_t              mr [3],
  input  m3i_pkg::cof_t               cof [m3i_pkg::NEL],
  output m3i_pkg::cmag_t              cmag [m3i_pkg::NEL],
  output logic [m3i_pkg::NEL-1:0]     qneg,
  output m3i_pkg::dmag_t              dmag,
  output logic                        zero
);

  localparam int CD_N = m3i_pkg::DET_ST - 1;

  logic [m3i_pkg::DW-1:0]     am [3];
  m3i_pkg::cmag_t             ac [3];
  logic [2:0]                 sg3;
  logic [2:0]                 sg4;
  logic [2:0]                 sg5;
  logic [m3i_pkg::PROD_W-1:0] lo [3];
  logic [m3i_pkg::PROD_W-1:0] hi [3];
  logic [m3i_pkg::TERM_W-1:0] tm [3];
  m3i_pkg::det_t              ts [3];
  m3i_pkg::det_t              det;
  m3i_pkg::cof_t              cd [CD_N][m3i_pkg::NEL];

  // Carry the cofactors alongside the determinant
  always_ff @(posedge clk) begin
    if (en[0]) begin
      cd[0] <= cof;
    end
    for (int s = 1; s < CD_N; s++) begin
      if (en[s]) begin
        cd[s] <= cd[s-1];
      end
    end
  end

  // Split signs off the first-row terms
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int t = 0; t < 3; t++) begin
        am[t] <= mr[t][m3i_pkg::DW-1] ? m3i_pkg::DW'(-mr[t]) : m3i_pkg::DW'(mr[t]);
        ac[t] <= cof[t][m3i_pkg::COF_W-1] ? m3i_pkg::CMAG_W'(-cof[t])
                                          : m3i_pkg::CMAG_W'(cof[t]);
        sg3[t] <= mr[t][m3i_pkg::DW-1] ^ cof[t][m3i_pkg::COF_W-1];
      end
    end
  end

  // Partial products, low and high cofactor halves
  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int t = 0; t < 3; t++) begin
        lo[t] <= am[t] * ac[t][m3i_pkg::DW-1:0];
        hi[t] <= am[t] * ac[t][m3i_pkg::CMAG_W-1:m3i_pkg::DW];
      end
      sg4 <= sg3;
    end
  end

  // Combine partial products
  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int t = 0; t < 3; t++) begin
        tm[t] <= {hi[t][m3i_pkg::TERM_W-m3i_pkg::DW-1:0], {m3i_pkg::DW{1'b0}}}
                 + m3i_pkg::TERM_W'(lo[t]);
      end
      sg5 <= sg4;
    end
  end

  // Restore term signs
  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int t = 0; t < 3; t++) begin
        ts[t] <= sg5[t] ? -m3i_pkg::det_t'({2'b00, tm[t]})
                        : m3i_pkg::det_t'({2'b00, tm[t]});
      end
    end
  end

  // Sum the expansion along the first row
  always_ff @(posedge clk) begin
    if (en[4]) begin
      det <= ts[0] + ts[1] + ts[2];
    end
  end

  // Magnitudes and quotient signs for the divider lanes
  always_ff @(posedge clk) begin
    if (en[5]) begin
      dmag <= det[m3i_pkg::DET_W-1] ? m3i_pkg::DMAG_W'(-det) : m3i_pkg::DMAG_W'(det);
      zero <= (det == '0);
      for (int i = 0; i < m3i_pkg::NEL; i++) begin
        cmag[i] <= cd[CD_N-1][i][m3i_pkg::COF_W-1] ? m3i_pkg::CMAG_W'(-cd[CD_N-1][i])
                                                   : m3i_pkg::CMAG_W'(cd[CD_N-1][i]);
        qneg[i] <= cd[CD_N-1][i][m3i_pkg::COF_W-1] ^ det[m3i_pkg::DET_W-1];
      end
    end
  end

endmodule

// ===== rtl/m3i_div.sv =====
module m3i_div (
  input  logic                        clk,
  input  logic [m3i_pkg::DIV_ST-1:0]  en,
  input  m3i_pkg::cmag_t              cmag,
  input  logic                        qneg,
  input  m3i_pkg::dmag_t              dmag,
  input  logic                        zero,
  output m3i_pkg::elem_t              res
);

  localparam int QB = m3i_pkg::QB;
  localparam int RW = m3i_pkg::REM_W;
  localparam int DW = m3i_pkg::DW;

  m3i_pkg::rem_t        rem [QB+1];
  logic [m3i_pkg::QW-1:0] quo [QB+1];
  m3i_pkg::dmag_t       dm  [QB+1];
  logic [QB:0]          ovf;
  logic [QB:0]          ng;
  logic [QB:0]          zr;

  m3i_pkg::rem_t cm_x;
  m3i_pkg::rem_t dm_x;
  m3i_pkg::rem_t dm2_x;
  logic          ge0;

  assign cm_x  = RW'(cmag);
  assign dm_x  = RW'(dmag);
  assign dm2_x = {dmag, 1'b0};
  assign ge0   = (cm_x >= dm_x);

  // Top quotient bit and overflow check
  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem[0] <= ge0 ? cm_x - dm_x : cm_x;
      quo[0] <= m3i_pkg::QW'(ge0);
      ovf[0] <= (cm_x >= dm2_x);
      dm[0]  <= dmag;
      ng[0]  <= qneg;
      zr[0]  <= zero;
    end
  end

  // One restoring step per stage
  for (genvar k = 1; k <= QB; k++) begin : g_step
    m3i_pkg::rem_t sh;
    logic          ge;

    assign sh = {rem[k-1][RW-2:0], 1'b0};
    assign ge = (sh >= RW'(dm[k-1]));

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem[k] <= ge ? sh - RW'(dm[k-1]) : sh;
        quo[k] <= {quo[k-1][m3i_pkg::QW-2:0], ge};
        ovf[k] <= ovf[k-1];
        dm[k]  <= dm[k-1];
        ng[k]  <= ng[k-1];
        zr[k]  <= zr[k-1];
      end
    end
  end

  logic [DW-1:0] lim;
  logic [DW-1:0] mag;

  // Saturate to the signed range
  always_comb begin
    lim = ng[QB] ? m3i_pkg::LIM_NEG : m3i_pkg::LIM_POS;
    if (ovf[QB] || (quo[QB] >= m3i_pkg::QW'(lim))) begin
      mag = lim;
    end else begin
      mag = quo[QB][DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[QB+1]) begin
      res <= zr[QB] ? '0 : (ng[QB] ? m3i_pkg::elem_t'(-mag) : m3i_pkg::elem_t'(mag));
    end
  end

endmodule

// ===== rtl/matrix_3x3_inverse.sv =====
// 3x3 matrix inverse by the adjugate, signed Q16.16 in and out, column-major.
// Cofactors and determinant are exact; each inverse element is the cofactor
// times 2^32 divided by the determinant, truncated toward zero and saturated.
// A zero determinant raises singular and returns all-zero elements. One
// request is accepted per clock when the output side keeps up; requests pass
// through the nine cofactor lanes, the determinant multiply and sum, and the
// nine pipelined restoring dividers (one quotient bit per stage). Every stage
// holds independently, so bubbles are squeezed out while a finished result
// waits at the output register.
module matrix_3x3_inverse (
  input logic       clk,
  input logic       rst,
  m3i_in_if.sink    mat,
  m3i_out_if.source inv
);

  localparam int NST = m3i_pkg::NST;
  localparam int NEL = m3i_pkg::NEL;

  logic [NST:0]   en;
  logic [NST-1:0] v;
  logic [NST-1:0] v_in;

  m3i_pkg::elem_t m [NEL];
  m3i_pkg::elem_t mr1 [3];
  m3i_pkg::elem_t mr2 [3];
  m3i_pkg::cof_t  cof [NEL];
  m3i_pkg::cmag_t cmag [NEL];
  logic [NEL-1:0] qneg;
  m3i_pkg::dmag_t dmag;
  logic           zero;
  m3i_pkg::elem_t res [NEL];
  logic [m3i_pkg::DIV_ST-1:0] sing;

  assign m[0] = mat.in_m0;
  assign m[1] = mat.in_m1;
  assign m[2] = mat.in_m2;
  assign m[3] = mat.in_m3;
  assign m[4] = mat.in_m4;
  assign m[5] = mat.in_m5;
  assign m[6] = mat.in_m6;
  assign m[7] = mat.in_m7;
  assign m[8] = mat.in_m8;

  // Per-stage advance: a stage loads when empty or when its successor moves
  assign en[NST] = inv.ready;
  for (genvar k = 0; k < NST; k++) begin : g_en
    assign en[k] = !v[k] | en[k+1];
  end

  assign v_in = {v[NST-2:0], mat.valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= (en[NST-1:0] & v_in) | (~en[NST-1:0] & v);
    end
  end

  assign mat.ready = en[0];

  // Hold first-row elements until the cofactors arrive
  always_ff @(posedge clk) begin
    if (en[m3i_pkg::COF_BASE]) begin
      mr1 <= '{m[0], m[3], m[6]};
    end
    if (en[m3i_pkg::COF_BASE+1]) begin
      mr2 <= mr1;
    end
  end

  // Cofactor lanes
  for (genvar i = 0; i < NEL; i++) begin : g_cof
    m3i_cof u_cof (
      .clk (clk),
      .en  (en[m3i_pkg::COF_BASE +: m3i_pkg::COF_ST]),
      .a   (m[m3i_pkg::COF_IDX[i][0]]),
      .b   (m[m3i_pkg::COF_IDX[i][1]]),
      .c   (m[m3i_pkg::COF_IDX[i][2]]),
      .d   (m[m3i_pkg::COF_IDX[i][3]]),
      .cof (cof[i])
    );
  end

  // Determinant merge
  m3i_det u_det (
    .clk  (clk),
    .en   (en[m3i_pkg::DET_BASE +: m3i_pkg::DET_ST]),
    .mr   (mr2),
    .cof  (cof),
    .cmag (cmag),
    .qneg (qneg),
    .dmag (dmag),
    .zero (zero)
  );

  // Divider lanes
  for (genvar i = 0; i < NEL; i++) begin : g_div
    m3i_div u_div (
      .clk  (clk),
      .en   (en[m3i_pkg::DIV_BASE +: m3i_pkg::DIV_ST]),
      .cmag (cmag[i]),
      .qneg (qneg[i]),
      .dmag (dmag),
      .zero (zero),
      .res  (res[i])
    );
  end

  // Track the singular flag through the divider stages
  always_ff @(posedge clk) begin
    for (int k = 0; k < m3i_pkg::DIV_ST; k++) begin
      if (en[m3i_pkg::DIV_BASE+k]) begin
        sing[k] <= (k == 0) ? zero : sing[(k == 0) ? 0 : k - 1];
      end
    end
  end

  assign inv.valid    = v[NST-1];
  assign inv.inv_m0   = res[0];
  assign inv.inv_m1   = res[1];
  assign inv.inv_m2   = res[2];
  assign inv.inv_m3   = res[3];
  assign inv.inv_m4   = res[4];
  assign inv.inv_m5   = res[5];
  assign inv.inv_m6   = res[6];
  assign inv.inv_m7   = res[7];
  assign inv.inv_m8   = res[8];
  assign inv.singular = sing[m3i_pkg::DIV_ST-1];

  // A singular result carries an all-zero inverse
  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    inv.valid && inv.singular |->
      inv.inv_m0 == '0 && inv.inv_m1 == '0 && inv.inv_m2 == '0 &&
      inv.inv_m3 == '0 && inv.inv_m4 == '0 && inv.inv_m5 == '0 &&
      inv.inv_m6 == '0 && inv.inv_m7 == '0 && inv.inv_m8 == '0)
    else $error("singular result with nonzero elements");

  // An empty pipeline always takes a request
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    v == '0 |-> mat.ready)
    else $error("empty pipeline refused a request");

  // Backpressure reaches the input only when every stage is full
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !mat.ready |-> (&v) && !inv.ready)
    else $error("input stalled with a bubble in the pipeline");

endmodule

// ===== dv/matrix_3x3_inverse_tb.sv =====
module matrix_3x3_inverse_tb;

  localparam int N_RANDOM = 930;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES = 300;

  // Q16.16 codes used in the directed rows
  localparam m3i_pkg::elem_t ONE = 32'sh0001_0000;
  localparam m3i_pkg::elem_t TWO = 32'sh0002_0000;
  localparam m3i_pkg::elem_t HALF = 32'sh0000_8000;
  localparam m3i_pkg::elem_t EMAX = 32'sh7fff_ffff;
  localparam m3i_pkg::elem_t EMIN = 32'sh8000_0000;
  localparam m3i_pkg::elem_t LSB = 32'sh0000_0001;

  typedef logic signed [191:0] wide_t;
  typedef logic [191:0] umag_t;

  typedef struct {
    m3i_pkg::elem_t el[m3i_pkg::NEL];
  } matrix_t;

  typedef struct {
    m3i_pkg::elem_t el[m3i_pkg::NEL];
    logic singular;
  } inverse_t;

  typedef struct {
    matrix_t m;
    bit known;
    inverse_t res;
  } row_t;

  typedef enum int {
    GEN_FULL,
    GEN_SMALL,
    GEN_DIAG,
    GEN_SINGULAR,
    GEN_SPARSE
  } gen_mode_t;

  logic clk;
  logic rst;

  m3i_in_if mat_if ();
  m3i_out_if inv_if ();

  matrix_3x3_inverse i_dut (
    .clk(clk),
    .rst(rst),
    .mat(mat_if),
    .inv(inv_if)
  );

  inverse_t pending_inv[$];
  row_t directed_rows[$];
  int mismatches;
  int idle_cycles;
  int results_seen;
  bit failed;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Predict the inverse: exact cofactors and determinant, truncating divide, saturate
  function automatic inverse_t predict_inverse(matrix_t m);
    inverse_t r;
    wide_t c[m3i_pkg::NEL];
    wide_t det;
    wide_t num;
    umag_t nmag;
    umag_t dmag;
    umag_t q;
    umag_t lim;
    bit neg;
    for (int k = 0; k < m3i_pkg::NEL; k++) begin
      c[k] = wide_t'(m.el[m3i_pkg::COF_IDX[k][0]]) * wide_t'(m.el[m3i_pkg::COF_IDX[k][1]])
           - wide_t'(m.el[m3i_pkg::COF_IDX[k][2]]) * wide_t'(m.el[m3i_pkg::COF_IDX[k][3]]);
    end
    det = wide_t'(m.el[0]) * c[0] + wide_t'(m.el[3]) * c[1]
        + wide_t'(m.el[6]) * c[2];
    r.singular = (det == 0);
    for (int k = 0; k < m3i_pkg::NEL; k++) begin
      r.el[k] = '0;
      if (det != 0) begin
        num = c[k] <<< (2 * m3i_pkg::FW);
        neg = (num < 0) ^ (det < 0);
        nmag = (num < 0) ? umag_t'(-num) : umag_t'(num);
        dmag = (det < 0) ? umag_t'(-det) : umag_t'(det);
        q = nmag / dmag;
        if (q == 0) neg = 1'b0;
        lim = neg ? (umag_t'(1) << (m3i_pkg::DW - 1))
                  : ((umag_t'(1) << (m3i_pkg::DW - 1)) - 1);
        if (q > lim) q = lim;
        r.el[k] = neg ? m3i_pkg::elem_t'(-q) : m3i_pkg::elem_t'(q);
      end
    end
    return r;
  endfunction

  function automatic matrix_t mk(input m3i_pkg::elem_t a0, a1, a2, a3, a4, a5, a6, a7, a8);
    matrix_t m;
    m.el = '{a0, a1, a2, a3, a4, a5, a6, a7, a8};
    return m;
  endfunction

  function automatic inverse_t mk_inv(input m3i_pkg::elem_t a0, a4, a8, input logic sing);
    inverse_t r;
    r.el = '{a0, 0, 0, 0, a4, 0, 0, 0, a8};
    r.singular = sing;
    return r;
  endfunction

  function automatic void add_row(matrix_t m, bit known, inverse_t res);
    row_t r;
    r.m = m;
    r.known = known;
    r.res = res;
    directed_rows.push_back(r);
  endfunction

  function automatic m3i_pkg::elem_t rand_elem(gen_mode_t mode);
    m3i_pkg::elem_t e;
    case (mode)
      GEN_SMALL: begin
        e = m3i_pkg::elem_t'($urandom_range(0, 32'h0008_0000))
          - m3i_pkg::elem_t'(32'h0004_0000);
      end
      GEN_SPARSE: begin
        e = ($urandom_range(0, 1) == 0) ? '0 : m3i_pkg::elem_t'($urandom());
      end
      default: begin
        e = m3i_pkg::elem_t'($urandom());
        case ($urandom_range(0, 7))
          0: e = EMAX;
          1: e = EMIN;
          2: e = e >>> $urandom_range(0, 31);
          default: ;
        endcase
      end
    endcase
    return e;
  endfunction

  function automatic matrix_t rand_matrix();
    matrix_t m;
    gen_mode_t mode;
    int src;
    int dst;
    mode = gen_mode_t'($urandom_range(0, 4));
    for (int k = 0; k < m3i_pkg::NEL; k++) begin
      m.el[k] = rand_elem((mode == GEN_SPARSE) ? GEN_SPARSE
                          : (mode == GEN_FULL) ? GEN_FULL : GEN_SMALL);
    end
    case (mode)
      GEN_DIAG: begin
        m.el[0] = m.el[0] + 32'sh0010_0000;
        m.el[4] = m.el[4] - 32'sh0010_0000;
        m.el[8] = m.el[8] + 32'sh0010_0000;
      end
      GEN_SINGULAR: begin
        // copy one column onto another, zeroing each copied entry at random
        src = $urandom_range(0, 2);
        dst = (src + $urandom_range(1, 2)) % 3;
        for (int r = 0; r < 3; r++) begin
          m.el[dst * 3 + r] = ($urandom_range(0, 3) == 0) ? '0 : m.el[src * 3 + r];
        end
      end
      default: ;
    endcase
    return m;
  endfunction

  // Offer one request with a random lead gap; hold valid across back-to-back requests
  task automatic send_matrix(matrix_t m, int gap, row_t row, bit use_row);
    inverse_t exp_inv;
    if (gap > 0) begin
      mat_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    mat_if.valid <= 1'b1;
    mat_if.in_m0 <= m.el[0];
    mat_if.in_m1 <= m.el[1];
    mat_if.in_m2 <= m.el[2];
    mat_if.in_m3 <= m.el[3];
    mat_if.in_m4 <= m.el[4];
    mat_if.in_m5 <= m.el[5];
    mat_if.in_m6 <= m.el[6];
    mat_if.in_m7 <= m.el[7];
    mat_if.in_m8 <= m.el[8];
    do @(posedge clk); while (!mat_if.ready);
    exp_inv = (use_row && row.known) ? row.res : predict_inverse(m);
    pending_inv.push_back(exp_inv);
  endtask

  // Sender: directed table, then random matrices
  initial begin
    row_t none_row;
    int burst;
    int gap;
    mat_if.valid <= 1'b0;
    mat_if.in_m0 <= '0;
    mat_if.in_m1 <= '0;
    mat_if.in_m2 <= '0;
    mat_if.in_m3 <= '0;
    mat_if.in_m4 <= '0;
    mat_if.in_m5 <= '0;
    mat_if.in_m6 <= '0;
    mat_if.in_m7 <= '0;
    mat_if.in_m8 <= '0;
    rst <= 1'b1;
    none_row.known = 1'b0;
    burst = 0;

    add_row(mk(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE), 1, mk_inv(ONE, ONE, ONE, 0));
    add_row(mk(TWO, 0, 0, 0, TWO, 0, 0, 0, TWO), 1, mk_inv(HALF, HALF, HALF, 0));
    add_row(mk(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, mk_inv(0, 0, 0, 1));
    add_row(mk(EMAX, EMAX, EMAX, EMAX, EMAX, EMAX, EMAX, EMAX, EMAX), 1, mk_inv(0, 0, 0, 1));
    add_row(mk(EMIN, EMIN, EMIN, EMIN, EMIN, EMIN, EMIN, EMIN, EMIN), 1, mk_inv(0, 0, 0, 1));
    // tiny diagonal: inverse overflows to the positive and negative limits
    add_row(mk(LSB, 0, 0, 0, LSB, 0, 0, 0, LSB), 1, mk_inv(EMAX, EMAX, EMAX, 0));
    add_row(mk(-LSB, 0, 0, 0, LSB, 0, 0, 0, LSB), 1, mk_inv(EMIN, EMAX, EMAX, 0));
    add_row(mk(EMAX, 0, 0, 0, EMAX, 0, 0, 0, EMAX), 0, none_row.res);
    add_row(mk(EMIN, 0, 0, 0, EMIN, 0, 0, 0, EMIN), 0, none_row.res);
    add_row(mk(EMIN, 0, 0, 0, EMAX, 0, 0, 0, EMIN), 0, none_row.res);
    add_row(mk(EMAX, EMIN, 0, EMIN, EMAX, EMIN, 0, EMIN, EMAX), 0, none_row.res);
    add_row(mk(EMIN, EMAX, EMIN, EMAX, EMIN, EMAX, EMIN, EMAX, EMIN), 0, none_row.res);
    add_row(mk(0, ONE, 0, 0, 0, ONE, ONE, 0, 0), 0, none_row.res);
    add_row(mk(ONE, TWO, ONE, TWO, ONE, TWO, ONE, ONE, TWO), 0, none_row.res);
    add_row(mk(ONE, TWO, 0, TWO, 32'sh0004_0000, 0, 0, 0, ONE), 1, mk_inv(0, 0, 0, 1));
    add_row(mk(-ONE, 0, 0, 0, -TWO, 0, 0, 0, -HALF), 0, none_row.res);
    add_row(mk(HALF, LSB, -LSB, LSB, HALF, LSB, -LSB, LSB, HALF), 0, none_row.res);
    add_row(mk(32'sh5555_5555, 32'shaaaa_aaaa, 32'sh0f0f_0f0f, 32'shf0f0_f0f0, ONE,
               32'sh3333_3333, 32'shcccc_cccc, 32'sh0000_ffff, 32'shffff_0000),
            0, none_row.res);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // walk the directed table
    foreach (directed_rows[i]) begin
      gap = (i < 6) ? 0 : $urandom_range(0, 3);
      send_matrix(directed_rows[i].m, gap, directed_rows[i], 1'b1);
    end

    // random part with idle stretches and one full drain
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 2) begin
        mat_if.valid <= 1'b0;
        while (pending_inv.size() != 0) @(posedge clk);
      end
      if (burst > 0) begin
        burst--;
        gap = 0;
      end else begin
        gap = $urandom_range(0, 15);
        if ($urandom_range(0, 19) == 0) burst = $urandom_range(20, 60);
      end
      send_matrix(rand_matrix(), gap, none_row, 1'b0);
    end
    mat_if.valid <= 1'b0;

    // drain and report
    while (pending_inv.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed && mismatches == 0 && pending_inv.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Receiver: random stalls, one long hold-off, compare against the oldest prediction
  initial begin
    inverse_t got;
    inverse_t exp_inv;
    bit bad;
    int burst;
    int gap;
    bit held;
    inv_if.ready <= 1'b0;
    mismatches = 0;
    results_seen = 0;
    failed = 1'b0;
    burst = 0;
    held = 1'b0;
    @(negedge rst);
    forever begin
      if (!held && results_seen == 100) begin
        held = 1'b1;
        gap = HOLD_CYCLES;
      end else if (burst > 0) begin
        burst--;
        gap = 0;
      end else begin
        gap = $urandom_range(0, 15);
        if ($urandom_range(0, 19) == 0) burst = $urandom_range(20, 60);
      end
      if (gap > 0) begin
        inv_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      inv_if.ready <= 1'b1;
      do @(posedge clk); while (!inv_if.valid);
      got.el = '{inv_if.inv_m0, inv_if.inv_m1, inv_if.inv_m2, inv_if.inv_m3, inv_if.inv_m4,
                 inv_if.inv_m5, inv_if.inv_m6, inv_if.inv_m7, inv_if.inv_m8};
      got.singular = inv_if.singular;
      results_seen++;
      if (pending_inv.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        exp_inv = pending_inv.pop_front();
        bad = (got.singular !== exp_inv.singular);
        for (int k = 0; k < m3i_pkg::NEL; k++) begin
          if (got.el[k] !== exp_inv.el[k]) bad = 1'b1;
        end
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch on result %0d: singular exp %0b got %0b",
                     results_seen, exp_inv.singular, got.singular);
            for (int k = 0; k < m3i_pkg::NEL; k++) begin
              $display("  inv_m%0d exp %h got %h", k, exp_inv.el[k], got.el[k]);
            end
          end
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (mat_if.valid && mat_if.ready) || (inv_if.valid && inv_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

endmodule

// ===== files.f =====
rtl/m3i_pkg.sv
rtl/m3i_in_if.sv
rtl/m3i_out_if.sv
rtl/m3i_cof.sv
rtl/m3i_det.sv
rtl/m3i_div.sv
rtl/matrix_3x3_inverse.sv
dv/matrix_3x3_inverse_tb.sv
